// ===== sv/pal_pkg.sv =====
// shared constants and types for the positional array list unit
// no dependencies; imported by the channel interfaces, the top level and the checker
package pal_pkg;

  // list storage size and derived widths
  localparam int CAPACITY = 32;
  localparam int ADDR_W   = $clog2(CAPACITY);
  localparam int CNT_W    = $clog2(CAPACITY + 1);
  localparam int POS_W    = 6;
  localparam int CMP_W    = (CNT_W > POS_W) ? CNT_W : POS_W;
  localparam int MAX_OUT  = 32;

  // field widths
  localparam int TYPE_W   = 3;
  localparam int DATA_W   = 32;
  localparam int STATUS_W = 2;
  localparam int INDEX_W  = 5;
  localparam int COUNT_W  = 6;

  typedef logic [TYPE_W-1:0]          req_type_t;
  typedef logic [POS_W-1:0]           position_t;
  typedef logic signed [DATA_W-1:0]   value_t;
  typedef logic [STATUS_W-1:0]        status_t;
  typedef logic [INDEX_W-1:0]         index_t;
  typedef logic [COUNT_W-1:0]         count_t;

  // request kinds
  localparam req_type_t REQ_INSERT    = 3'd0;
  localparam req_type_t REQ_DEL_FIRST = 3'd1;
  localparam req_type_t REQ_DEL_MID   = 3'd2;
  localparam req_type_t REQ_DEL_LAST  = 3'd3;
  localparam req_type_t REQ_READOUT   = 3'd4;

  // result status codes
  localparam status_t ST_OK     = 2'd0;
  localparam status_t ST_BADPOS = 2'd1;
  localparam status_t ST_EMPTY  = 2'd2;
  localparam status_t ST_FULL   = 2'd3;

endpackage

// ===== sv/pal_req_if.sv =====
// request channel: valid/ready handshake with the list request payload
// depends on pal_pkg
interface pal_req_if;
  import pal_pkg::*;

  logic      valid;
  logic      ready;
  req_type_t req_type;
  position_t position;
  value_t    value;

  modport source (output valid, output req_type, output position, output value,
                  input ready);
  modport sink (input valid, input req_type, input position, input value,
                output ready);
endinterface

// ===== sv/pal_rsp_if.sv =====
// result channel: valid/ready handshake with the list result payload
// depends on pal_pkg
interface pal_rsp_if;
  import pal_pkg::*;

  logic    valid;
  logic    ready;
  status_t status;
  value_t  entry_value;
  index_t  entry_index;
  count_t  entry_count;
  logic    last;

  modport source (output valid, output status, output entry_value, output entry_index,
                  output entry_count, output last, input ready);
  modport sink (input valid, input status, input entry_value, input entry_index,
                input entry_count, input last, output ready);
endinterface

// ===== sv/positional_array_list_unit.sv =====
// positional array list: ordered list of signed values held in one synchronous memory
// depends on pal_pkg, pal_req_if, pal_rsp_if
// timing: status-only requests and edits that move no entry load their result straight into
//   the result register when the request is accepted; an insert moves count-position entries
//   before its result, a delete moves count-at-1 entries before its result
// throughput: one memory entry moved per cycle over the single read and write port;
//   readout gives one result per cycle while the result slot is free, from registered read data
// reset: synchronous rst empties the list (count zero); the memory itself is not cleared
module positional_array_list_unit (
  input  logic clk,
  input  logic rst,
  pal_req_if.sink   req,
  pal_rsp_if.source rsp
);
  import pal_pkg::*;

  // sequencer states
  localparam logic [2:0] S_IDLE = 3'd0;
  localparam logic [2:0] S_SHUP = 3'd1;
  localparam logic [2:0] S_INSW = 3'd2;
  localparam logic [2:0] S_SHDN = 3'd3;
  localparam logic [2:0] S_READ = 3'd4;
  localparam logic [2:0] S_DONE = 3'd5;

  logic [2:0]        state, state_next;
  logic [CNT_W-1:0]  count, count_next;
  logic [ADDR_W-1:0] wptr, wptr_next;
  logic [ADDR_W-1:0] pos_r, pos_next;
  logic [DATA_W-1:0] val_r, val_next;

  // list memory
  logic [DATA_W-1:0] mem [CAPACITY];
  logic [DATA_W-1:0] rd_data;
  logic              mem_we, mem_re;
  logic [ADDR_W-1:0] waddr, raddr;
  logic [DATA_W-1:0] wdata;

  // result staging
  logic              slot_free, accept, load;
  status_t           o_status;
  logic [DATA_W-1:0] o_value;
  index_t            o_index;
  logic              o_last;
  logic              rd_last;
  logic [ADDR_W-1:0] mid_at;

  assign slot_free = !rsp.valid || rsp.ready;
  assign req.ready = (state == S_IDLE) && slot_free;
  assign accept    = req.valid && req.ready;
  assign mid_at    = (req.req_type == REQ_DEL_MID) ? ADDR_W'(count >> 1) : '0;
  assign rd_last   = ((CNT_W + 1)'(wptr) + 1'b1 == (CNT_W + 1)'(count)) ||
                     (32'(wptr) == MAX_OUT - 1);

  // sequencer and memory control
  always_comb begin
    state_next = state;
    count_next = count;
    wptr_next  = wptr;
    pos_next   = pos_r;
    val_next   = val_r;
    mem_we     = 1'b0;
    waddr      = wptr;
    wdata      = rd_data;
    mem_re     = 1'b0;
    raddr      = wptr;
    load       = 1'b0;
    o_status   = ST_OK;
    o_value    = '0;
    o_index    = '0;
    o_last     = 1'b1;
    case (state)
      S_IDLE: begin
        if (accept) begin
          case (req.req_type)
            REQ_INSERT: begin
              if (32'(count) == CAPACITY) begin
                load     = 1'b1;
                o_status = ST_FULL;
              end else if (CMP_W'(req.position) > CMP_W'(count)) begin
                load     = 1'b1;
                o_status = ST_BADPOS;
              end else if (CMP_W'(req.position) == CMP_W'(count)) begin
                mem_we     = 1'b1;
                waddr      = ADDR_W'(req.position);
                wdata      = req.value;
                count_next = count + 1'b1;
                load       = 1'b1;
              end else begin
                mem_re     = 1'b1;
                raddr      = ADDR_W'(count - 1'b1);
                wptr_next  = ADDR_W'(count);
                pos_next   = ADDR_W'(req.position);
                val_next   = req.value;
                state_next = S_SHUP;
              end
            end
            REQ_DEL_FIRST, REQ_DEL_MID: begin
              if (count == '0) begin
                load     = 1'b1;
                o_status = ST_EMPTY;
              end else if (CNT_W'(mid_at) + 1'b1 < count) begin
                mem_re     = 1'b1;
                raddr      = mid_at + 1'b1;
                wptr_next  = mid_at;
                state_next = S_SHDN;
              end else begin
                count_next = count - 1'b1;
                load       = 1'b1;
              end
            end
            REQ_DEL_LAST: begin
              load = 1'b1;
              if (count == '0) begin
                o_status = ST_EMPTY;
              end else begin
                count_next = count - 1'b1;
              end
            end
            REQ_READOUT: begin
              if (count == '0) begin
                load     = 1'b1;
                o_status = ST_EMPTY;
              end else begin
                mem_re     = 1'b1;
                raddr      = '0;
                wptr_next  = '0;
                state_next = S_READ;
              end
            end
            default: begin
              load = 1'b1;
            end
          endcase
        end
      end
      // move entries up, top first, until the insert slot is open
      S_SHUP: begin
        mem_we = 1'b1;
        waddr  = wptr;
        wdata  = rd_data;
        if (wptr == pos_r + 1'b1) begin
          state_next = S_INSW;
        end else begin
          mem_re    = 1'b1;
          raddr     = wptr - ADDR_W'(2);
          wptr_next = wptr - 1'b1;
        end
      end
      // write the new value into the open slot
      S_INSW: begin
        mem_we     = 1'b1;
        waddr      = pos_r;
        wdata      = val_r;
        count_next = count + 1'b1;
        state_next = S_DONE;
      end
      // move entries down over the deleted one
      S_SHDN: begin
        mem_we = 1'b1;
        waddr  = wptr;
        wdata  = rd_data;
        if (CNT_W'(wptr) + CNT_W'(2) < count) begin
          mem_re    = 1'b1;
          raddr     = wptr + ADDR_W'(2);
          wptr_next = wptr + 1'b1;
        end else begin
          count_next = count - 1'b1;
          state_next = S_DONE;
        end
      end
      // stream entries out, one per cycle when the result slot is free
      S_READ: begin
        if (slot_free) begin
          load    = 1'b1;
          o_value = rd_data;
          o_index = INDEX_W'(wptr);
          o_last  = rd_last;
          if (rd_last) begin
            state_next = S_IDLE;
          end else begin
            mem_re    = 1'b1;
            raddr     = wptr + 1'b1;
            wptr_next = wptr + 1'b1;
          end
        end
      end
      S_DONE: begin
        if (slot_free) begin
          load       = 1'b1;
          state_next = S_IDLE;
        end
      end
      default: begin
        state_next = S_IDLE;
      end
    endcase
  end

  // memory ports; read data holds while no read is issued
  always_ff @(posedge clk) begin
    if (mem_we) begin
      mem[waddr] <= wdata;
    end
    if (mem_re) begin
      rd_data <= mem[raddr];
    end
  end

  // control registers
  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
      count <= '0;
    end else begin
      state <= state_next;
      count <= count_next;
    end
    wptr  <= wptr_next;
    pos_r <= pos_next;
    val_r <= val_next;
  end

  // result register
  always_ff @(posedge clk) begin
    if (rst) begin
      rsp.valid <= 1'b0;
    end else if (load) begin
      rsp.valid <= 1'b1;
    end else if (rsp.ready) begin
      rsp.valid <= 1'b0;
    end
    if (load) begin
      rsp.status      <= o_status;
      rsp.entry_value <= $signed(o_value);
      rsp.entry_index <= o_index;
      rsp.entry_count <= COUNT_W'(count_next);
      rsp.last        <= o_last;
    end
  end

endmodule

// ===== sv/pal_checker.sv =====
// port-level checks for the positional array list unit, bound to the top level
// depends on pal_pkg and positional_array_list_unit
module pal_checker (
  input logic              clk,
  input logic              rst,
  input logic              rsp_valid,
  input logic              rsp_ready,
  input pal_pkg::status_t  rsp_status,
  input pal_pkg::value_t   rsp_entry_value,
  input pal_pkg::index_t   rsp_entry_index,
  input pal_pkg::count_t   rsp_entry_count,
  input logic              rsp_last
);
  import pal_pkg::*;

  // a stalled result keeps its value, status and last flag
  a_rsp_hold: assert property (@(posedge clk) disable iff (rst)
    rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp_entry_value) &&
      $stable(rsp_status) && $stable(rsp_last))
    else $error("result changed while stalled");

  // reset empties the result slot
  a_rst_clear: assert property (@(posedge clk) rst |=> !rsp_valid)
    else $error("result valid right after reset");

  // count never exceeds the list capacity
  a_count_range: assert property (@(posedge clk) disable iff (rst)
    rsp_valid |-> 32'(rsp_entry_count) <= CAPACITY)
    else $error("entry count above capacity");

  // error results are single, with no entry data
  a_err_single: assert property (@(posedge clk) disable iff (rst)
    rsp_valid && rsp_status != ST_OK |->
      rsp_last && rsp_entry_value == '0 && rsp_entry_index == '0)
    else $error("error result carries entry data or is not last");

  // readout results that are not last come from a list holding more entries
  a_stream_index: assert property (@(posedge clk) disable iff (rst)
    rsp_valid && !rsp_last |->
      rsp_status == ST_OK && 32'(rsp_entry_index) + 1 < 32'(rsp_entry_count))
    else $error("non-final result out of range");

endmodule

bind positional_array_list_unit pal_checker u_pal_checker (
  .clk             (clk),
  .rst             (rst),
  .rsp_valid       (rsp.valid),
  .rsp_ready       (rsp.ready),
  .rsp_status      (rsp.status),
  .rsp_entry_value (rsp.entry_value),
  .rsp_entry_index (rsp.entry_index),
  .rsp_entry_count (rsp.entry_count),
  .rsp_last        (rsp.last)
);

// ===== tb/pal_tb_pkg.sv =====
`timescale 1ns / 100ps
// list request and result records plus the scoreboard for the positional array list unit
// depends on pal_pkg
package pal_tb_pkg;
  import pal_pkg::*;

  // request kinds the block must ignore
  localparam req_type_t REQ_SPARE_FIRST = 3'd5;
  localparam req_type_t REQ_SPARE_LAST  = 3'd7;

  typedef struct {
    req_type_t kind;
    position_t pos;
    value_t    val;
  } list_request_t;

  typedef struct {
    status_t status;
    value_t  value;
    index_t  index;
    count_t  count;
    logic    last;
  } list_result_t;

  class list_scoreboard;
    value_t       slots[CAPACITY];
    int unsigned  fill;
    int unsigned  n_errors;
    list_result_t pending_results[$];

    function new();
      fill = 0;
      n_errors = 0;
    endfunction

    // queue one result, count taken after the edit
    function void expect_result(status_t st, value_t v, int unsigned idx, logic lst);
      list_result_t e;
      e.status = st;
      e.value  = v;
      e.index  = index_t'(idx);
      e.count  = count_t'(fill);
      e.last   = lst;
      pending_results.push_back(e);
    endfunction

    // apply an accepted request to the shadow list and queue its results
    function void note_request(list_request_t r);
      int unsigned i;
      int unsigned at;
      int unsigned n;
      status_t     st;
      st = ST_OK;
      case (r.kind)
        REQ_INSERT: begin
          // full check wins over the position check
          if (fill >= CAPACITY) st = ST_FULL;
          else if (r.pos > fill) st = ST_BADPOS;
          else begin
            for (i = fill; i > r.pos; i--) slots[i] = slots[i-1];
            slots[r.pos] = r.val;
            fill++;
          end
        end
        REQ_DEL_FIRST, REQ_DEL_MID, REQ_DEL_LAST: begin
          if (fill == 0) st = ST_EMPTY;
          else begin
            if (r.kind == REQ_DEL_FIRST) at = 0;
            else if (r.kind == REQ_DEL_MID) at = fill / 2;
            else at = fill - 1;
            for (i = at; i + 1 < fill; i++) slots[i] = slots[i+1];
            fill--;
          end
        end
        REQ_READOUT: begin
          if (fill == 0) expect_result(ST_EMPTY, '0, 0, 1'b1);
          else begin
            n = (fill < MAX_OUT) ? fill : MAX_OUT;
            for (i = 0; i < n; i++) expect_result(ST_OK, slots[i], i, i + 1 == n);
          end
          return;
        end
        default: ;
      endcase
      expect_result(st, '0, 0, 1'b1);
    endfunction

    // compare one accepted result against the oldest expectation
    function void check_result(list_result_t got);
      list_result_t want;
      if (pending_results.size() == 0) begin
        $error("unexpected result: status %0d value %0d index %0d count %0d last %0d",
               got.status, got.value, got.index, got.count, got.last);
        n_errors++;
        return;
      end
      want = pending_results.pop_front();
      if (got.status !== want.status) begin
        $error("status: expected %0d, got %0d", want.status, got.status);
        n_errors++;
      end
      if (got.value !== want.value) begin
        $error("entry_value: expected %0d, got %0d", want.value, got.value);
        n_errors++;
      end
      if (got.index !== want.index) begin
        $error("entry_index: expected %0d, got %0d", want.index, got.index);
        n_errors++;
      end
      if (got.count !== want.count) begin
        $error("entry_count: expected %0d, got %0d", want.count, got.count);
        n_errors++;
      end
      if (got.last !== want.last) begin
        $error("last: expected %0d, got %0d", want.last, got.last);
        n_errors++;
      end
    endfunction

    function int unsigned outstanding();
      return pending_results.size();
    endfunction
  endclass

endpackage

// ===== tb/testbench.sv =====
`timescale 1ns / 100ps
// top-level testbench: drives list requests into positional_array_list_unit and checks results
// depends on pal_pkg, pal_req_if, pal_rsp_if, pal_tb_pkg and the unit itself
module testbench;
  import pal_pkg::*;
  import pal_tb_pkg::*;

  localparam int unsigned GAP_MAX        = 11;
  localparam int unsigned RANDOM_ITEMS   = 390;
  localparam int unsigned CYCLE_LIMIT    = 1_000_000;
  localparam int unsigned DRAIN_CYCLES   = 40;
  localparam int unsigned HOLD_AT_RESULT = 50;
  localparam int unsigned HOLD_CYCLES    = 300;

  typedef enum {BIAS_GROW, BIAS_SHRINK, BIAS_EVEN} edit_bias_e;

  logic        clk = 1'b0;
  logic        rst = 1'b1;
  bit          no_idle = 1'b0;
  int unsigned cycle_count = 0;
  int unsigned results_taken = 0;

  list_scoreboard sb = new();

  pal_req_if req_ch();
  pal_rsp_if rsp_ch();

  positional_array_list_unit u_top (
    .clk (clk),
    .rst (rst),
    .req (req_ch),
    .rsp (rsp_ch)
  );

  // 10 ns clock
  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  // run watchdog
  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count >= CYCLE_LIMIT) begin
      $display("simulation failed");
      $finish;
    end
  end

  function automatic list_request_t make_request(req_type_t kind, position_t pos, value_t val);
    list_request_t r;
    r.kind = kind;
    r.pos  = pos;
    r.val  = val;
    return r;
  endfunction

  // random request shaped by the current edit bias and the shadow list fill
  function automatic list_request_t random_request(edit_bias_e bias);
    list_request_t r;
    int unsigned   roll;
    int unsigned   ins_lim;
    int unsigned   del_lim;
    roll = $urandom_range(0, 99);
    case ($urandom_range(0, 9))
      0: r.val = 32'sh7FFF_FFFF;
      1: r.val = 32'sh8000_0000;
      default: r.val = $urandom();
    endcase
    r.pos = position_t'($urandom_range(0, sb.fill));
    case (bias)
      BIAS_GROW: begin
        ins_lim = 85;
        del_lim = 90;
      end
      BIAS_SHRINK: begin
        ins_lim = 25;
        del_lim = 85;
      end
      default: begin
        ins_lim = 45;
        del_lim = 80;
      end
    endcase
    // noise: spare kinds and inserts at any position
    if (roll < 4) r.kind = req_type_t'($urandom_range(REQ_SPARE_FIRST, REQ_SPARE_LAST));
    else if (roll < 8) begin
      r.kind = REQ_INSERT;
      r.pos  = position_t'($urandom());
    end
    else if (roll < ins_lim) r.kind = REQ_INSERT;
    else if (roll < del_lim) r.kind = req_type_t'($urandom_range(REQ_DEL_FIRST, REQ_DEL_LAST));
    else r.kind = REQ_READOUT;
    return r;
  endfunction

  // offer one request, keep valid high across back-to-back requests
  task automatic send_request(list_request_t r);
    int unsigned gap;
    gap = no_idle ? 0 : $urandom_range(0, GAP_MAX);
    if (gap != 0) begin
      req_ch.valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    req_ch.valid    <= 1'b1;
    req_ch.req_type <= r.kind;
    req_ch.position <= r.pos;
    req_ch.value    <= r.val;
    @(posedge clk);
    while (!req_ch.ready) @(posedge clk);
    sb.note_request(r);
  endtask

  // result side: random stalls, one long hold-off to back up the block
  initial begin
    int unsigned  stall;
    list_result_t got;
    rsp_ch.ready <= 1'b0;
    @(posedge clk);
    while (rst) @(posedge clk);
    forever begin
      if (results_taken == HOLD_AT_RESULT) stall = HOLD_CYCLES;
      else stall = no_idle ? 0 : $urandom_range(0, GAP_MAX);
      if (stall != 0) begin
        rsp_ch.ready <= 1'b0;
        repeat (stall) @(posedge clk);
      end
      rsp_ch.ready <= 1'b1;
      @(posedge clk);
      while (!rsp_ch.valid) @(posedge clk);
      got.status = rsp_ch.status;
      got.value  = rsp_ch.entry_value;
      got.index  = rsp_ch.entry_index;
      got.count  = rsp_ch.entry_count;
      got.last   = rsp_ch.last;
      sb.check_result(got);
      results_taken++;
    end
  end

  // request side: reset, directed requests, then biased random phases
  initial begin
    int unsigned sent;
    int unsigned phase;
    int unsigned phase_len;
    edit_bias_e  bias;
    req_ch.valid    <= 1'b0;
    req_ch.req_type <= REQ_INSERT;
    req_ch.position <= '0;
    req_ch.value    <= '0;
    rst             <= 1'b1;
    repeat (6) @(posedge clk);
    rst <= 1'b0;

    // empty list: readout and every delete
    send_request(make_request(REQ_READOUT, '0, '0));
    send_request(make_request(REQ_DEL_FIRST, '0, '0));
    send_request(make_request(REQ_DEL_MID, '0, '0));
    send_request(make_request(REQ_DEL_LAST, '0, '0));
    // position past the count
    send_request(make_request(REQ_INSERT, 6'd1, 32'sd7));
    send_request(make_request(REQ_INSERT, 6'h3F, 32'sh7FFF_FFFF));
    // inserts at front, middle and end with extreme values
    send_request(make_request(REQ_INSERT, 6'd0, 32'sh7FFF_FFFF));
    send_request(make_request(REQ_INSERT, 6'd1, 32'sh8000_0000));
    send_request(make_request(REQ_INSERT, 6'd1, -32'sd1));
    send_request(make_request(REQ_INSERT, 6'd0, 32'sd0));
    send_request(make_request(REQ_INSERT, 6'd2, 32'sh5555_5555));
    send_request(make_request(REQ_INSERT, 6'd5, 32'shAAAA_AAAA));
    send_request(make_request(REQ_READOUT, '0, '0));
    // spare kinds are answered with the current count
    send_request(make_request(REQ_SPARE_FIRST, 6'd32, 32'sd1));
    send_request(make_request(req_type_t'(REQ_SPARE_FIRST + 1), 6'h3F, -32'sd1));
    send_request(make_request(REQ_SPARE_LAST, '0, 32'sh8000_0000));
    // deletes from each place
    send_request(make_request(REQ_DEL_MID, '0, '0));
    send_request(make_request(REQ_DEL_FIRST, '0, '0));
    send_request(make_request(REQ_DEL_LAST, '0, '0));
    send_request(make_request(REQ_READOUT, '0, '0));
    send_request(make_request(REQ_INSERT, 6'd32, 32'sd3));

    // random phases, the first one is biased to grow the list toward full
    sent  = 0;
    phase = 0;
    while (sent < RANDOM_ITEMS) begin
      if (phase == 0) begin
        bias      = BIAS_GROW;
        phase_len = 50;
      end else begin
        bias      = edit_bias_e'($urandom_range(0, 2));
        phase_len = $urandom_range(20, 50);
      end
      no_idle = (phase % 3 == 2);
      repeat (phase_len) begin
        if (sent < RANDOM_ITEMS) begin
          send_request(random_request(bias));
          sent++;
        end
      end
      phase++;
    end
    no_idle = 1'b0;
    req_ch.valid <= 1'b0;

    // drain outstanding results, then watch for strays
    while (sb.outstanding() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (sb.n_errors == 0 && sb.outstanding() == 0) begin
      $display("simulation ok");
    end else begin
      $display("simulation failed");
    end
    $finish;
  end

endmodule
